// ===== rtl/core/avte_pkg.sv =====
// ----------------------------------------------------------------------------
// avte_pkg
// shared types, op codes and parameters for the vertex transform engine
// ----------------------------------------------------------------------------
package avte_pkg;
  localparam int FRAC_BITS_DEF = 16;
  localparam int QDEPTH = 2;

  localparam logic [2:0] OP_WR_CUR  = 3'd0;
  localparam logic [2:0] OP_WR_PEND = 3'd1;
  localparam logic [2:0] OP_IDENT   = 3'd2;
  localparam logic [2:0] OP_CONCAT  = 3'd3;
  localparam logic [2:0] OP_XFORM   = 3'd4;
  localparam logic [2:0] OP_NOP     = 3'd5;

  typedef struct packed {
    logic [2:0]         op;
    logic [3:0]         idx;
    logic signed [31:0] val;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
  } cmd_t;
endpackage

// ===== rtl/core/avte_front.sv =====
// ----------------------------------------------------------------------------
// avte_front
// takes commands, folds undefined ops to a no-op, holds a two-entry queue
// ----------------------------------------------------------------------------
module avte_front import avte_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  cmd_t in_cmd,
  output logic full,
  output logic q_valid,
  output cmd_t q_cmd,
  input  logic q_pop
);
  cmd_t       mem_r [QDEPTH];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push;
  cmd_t       cls;

  assign full    = (cnt_r == 2'(QDEPTH));
  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd   = mem_r[rp_r];
  assign push    = start && !full;

  always_comb begin
    cls = in_cmd;
    if (in_cmd.op > OP_XFORM) cls.op = OP_NOP;
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= cls;
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end
endmodule

// ===== rtl/core/avte_back.sv =====
// ----------------------------------------------------------------------------
// avte_back
// matrix store and one shared multiply-accumulate sequencer
// ----------------------------------------------------------------------------
module avte_back import avte_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  cmd_t               q_cmd,
  output logic               q_pop,
  output logic               out_valid,
  output logic signed [31:0] out_qx,
  output logic signed [31:0] out_qy,
  output logic signed [31:0] out_qz,
  output logic               out_saturated
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_ACC  = 2'd2;
  localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

  logic signed [31:0] cur_r [16];
  logic signed [31:0] pend_r [16];
  logic signed [31:0] res_r [16];
  logic [1:0]  st_r;
  cmd_t        cmd_r;
  logic [3:0]  el_r;    // output element
  logic [2:0]  k_r;     // term index, 3 means translation for transform
  logic signed [63:0] prod_r, acc_r;
  logic        sat_r;
  logic signed [31:0] qx_r, qy_r, qz_r;
  logic        ov_r;

  logic signed [31:0] a_op, b_op, tsum;
  logic signed [63:0] nacc, term;
  logic        tclip;
  logic [1:0]  r_i, c_i;
  logic        last_term;

  assign r_i = el_r[3:2];
  assign c_i = el_r[1:0];
  assign q_pop = (st_r == S_IDLE) && q_valid;

  always_comb begin
    if (cmd_r.op == OP_CONCAT) begin
      a_op = pend_r[{r_i, k_r[1:0]}];
      b_op = cur_r[{k_r[1:0], c_i}];
    end else begin
      a_op = cur_r[{k_r[1:0], c_i}];
      case (k_r[1:0])
        2'd0:    b_op = cmd_r.px;
        2'd1:    b_op = cmd_r.py;
        2'd2:    b_op = cmd_r.pz;
        default: b_op = ONE;
      endcase
    end
    term = (cmd_r.op == OP_XFORM && k_r == 3'd3) ? 64'(a_op) : (prod_r >>> FRAC_BITS);
    nacc = acc_r + term;
    tclip = (nacc > 64'sd2147483647) || (nacc < -64'sd2147483648);
    if (nacc > 64'sd2147483647) tsum = 32'sh7fffffff;
    else if (nacc < -64'sd2147483648) tsum = 32'sh80000000;
    else tsum = nacc[31:0];
    last_term = (k_r == 3'd3);
  end

  always_ff @(posedge clk) begin
    prod_r <= a_op * b_op;
    if (!rst_n) begin
      st_r <= S_IDLE; ov_r <= 1'b0;
      for (int i = 0; i < 16; i++) begin
        cur_r[i]  <= (i % 5 == 0) ? ONE : 32'sd0;
        pend_r[i] <= (i % 5 == 0) ? ONE : 32'sd0;
      end
    end else begin
      ov_r <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (q_valid) begin
            cmd_r <= q_cmd; el_r <= 4'd0; k_r <= 3'd0;
            acc_r <= '0; sat_r <= 1'b0;
            qx_r <= '0; qy_r <= '0; qz_r <= '0;
            case (q_cmd.op)
              OP_WR_CUR: begin cur_r[q_cmd.idx] <= q_cmd.val; ov_r <= 1'b1; end
              OP_WR_PEND: begin pend_r[q_cmd.idx] <= q_cmd.val; ov_r <= 1'b1; end
              OP_IDENT: begin
                for (int i = 0; i < 16; i++) cur_r[i] <= (i % 5 == 0) ? ONE : 32'sd0;
                ov_r <= 1'b1;
              end
              OP_CONCAT, OP_XFORM: st_r <= S_MUL;
              default: ov_r <= 1'b1;
            endcase
          end
        end
        S_MUL: st_r <= S_ACC;  // product lands in prod_r
        S_ACC: begin
          if (!last_term) begin
            acc_r <= nacc; k_r <= k_r + 3'd1; st_r <= S_MUL;
          end else begin
            acc_r <= '0; k_r <= 3'd0; sat_r <= sat_r | tclip;
            if (cmd_r.op == OP_CONCAT) begin
              res_r[el_r] <= tsum;
              if (el_r == 4'd15) begin
                for (int i = 0; i < 15; i++) cur_r[i] <= res_r[i];
                cur_r[15] <= tsum;
                ov_r <= 1'b1; st_r <= S_IDLE;
              end else begin
                el_r <= el_r + 4'd1; st_r <= S_MUL;
              end
            end else begin
              case (c_i)
                2'd0: qx_r <= tsum;
                2'd1: qy_r <= tsum;
                default: qz_r <= tsum;
              endcase
              if (c_i == 2'd2) begin
                ov_r <= 1'b1; st_r <= S_IDLE;
              end else begin
                el_r <= el_r + 4'd1; st_r <= S_MUL;
              end
            end
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = ov_r;
  assign out_qx = qx_r;
  assign out_qy = qy_r;
  assign out_qz = qz_r;
  assign out_saturated = sat_r;
endmodule

// ===== rtl/core/affine_vertex_transform_engine.sv =====
// throughput: one write per cycle while busy is low; the sequencer works on one transform or concatenate at a time
// one shared 32x32 multiplier, used term by term for transform and concatenate
// a two-word queue lets commands be taken while the sequencer works
// result strobe out_valid is high one cycle; the receiver cannot stall
// synchronous active-low reset loads identity into both matrices
// ----------------------------------------------------------------------------
// affine_vertex_transform_engine
// 4x4 fixed point matrix unit with point transform and concatenation
// ----------------------------------------------------------------------------
module affine_vertex_transform_engine import avte_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_op,
  input  logic [3:0]         in_elem_index,
  input  logic signed [31:0] in_elem_value,
  input  logic signed [31:0] in_px,
  input  logic signed [31:0] in_py,
  input  logic signed [31:0] in_pz,
  output logic               out_valid,
  output logic signed [31:0] out_qx,
  output logic signed [31:0] out_qy,
  output logic signed [31:0] out_qz,
  output logic               out_saturated
);
  cmd_t in_cmd, q_cmd;
  logic q_valid, q_pop;

  assign in_cmd = '{op: in_op, idx: in_elem_index, val: in_elem_value,
                    px: in_px, py: in_py, pz: in_pz};

  avte_front u_front (
    .clk, .rst_n, .start, .in_cmd, .full(busy),
    .q_valid, .q_cmd, .q_pop
  );

  avte_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk, .rst_n, .q_valid, .q_cmd, .q_pop,
    .out_valid, .out_qx, .out_qy, .out_qz, .out_saturated
  );
endmodule

// ===== tb/sv/affine_vertex_transform_engine_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// affine_vertex_transform_engine_test
// drives matrix writes, identity, concatenation, point transforms and
// undefined ops through the command port; a fixed point matrix model in the
// bench predicts each result word, which is checked field by field
// ----------------------------------------------------------------------------
module affine_vertex_transform_engine_test;
  import avte_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam int IDLE_LIMIT = 20000;

  typedef struct {
    logic signed [31:0] qx;
    logic signed [31:0] qy;
    logic signed [31:0] qz;
    logic               sat;
  } vertex_word_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [2:0] in_op;
  logic [3:0] in_elem_index;
  logic signed [31:0] in_elem_value, in_px, in_py, in_pz;
  logic out_valid;
  logic signed [31:0] out_qx, out_qy, out_qz;
  logic out_saturated;

  logic signed [31:0] cur_mtx [16];
  logic signed [31:0] pend_mtx [16];
  vertex_word_t expected_words [$];
  int mismatches;
  int idle_cycles;
  bit gaps_on;
  bit done;

  affine_vertex_transform_engine u_dut (.*);

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  function automatic logic signed [63:0] fx_mul(logic signed [31:0] a, logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    return p >>> FB;
  endfunction

  function automatic logic signed [31:0] clip32(logic signed [63:0] v, ref logic clip);
    if (v > 64'sd2147483647) begin
      clip = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -64'sd2147483648) begin
      clip = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic void load_identity();
    for (int i = 0; i < 16; i++) cur_mtx[i] = (i % 5 == 0) ? (32'sd1 <<< FB) : 32'sd0;
  endfunction

  // works out the word one command yields and updates the model matrices
  function automatic vertex_word_t predict_vertex(cmd_t c);
    vertex_word_t w;
    logic signed [31:0] old [16];
    logic signed [63:0] acc;
    logic clip;
    clip = 1'b0;
    w.qx = 0; w.qy = 0; w.qz = 0;
    case (c.op)
      OP_WR_CUR: cur_mtx[c.idx] = c.val;
      OP_WR_PEND: pend_mtx[c.idx] = c.val;
      OP_IDENT: load_identity();
      OP_CONCAT: begin
        old = cur_mtx;
        for (int r = 0; r < 4; r++)
          for (int col = 0; col < 4; col++) begin
            acc = 0;
            for (int k = 0; k < 4; k++) acc += fx_mul(pend_mtx[4*r+k], old[4*k+col]);
            cur_mtx[4*r+col] = clip32(acc, clip);
          end
      end
      OP_XFORM: begin
        for (int i = 0; i < 3; i++) begin
          acc = fx_mul(cur_mtx[i], c.px) + fx_mul(cur_mtx[4+i], c.py)
              + fx_mul(cur_mtx[8+i], c.pz) + 64'(cur_mtx[12+i]);
          if (i == 0) w.qx = clip32(acc, clip);
          else if (i == 1) w.qy = clip32(acc, clip);
          else w.qz = clip32(acc, clip);
        end
      end
      default: ;
    endcase
    w.sat = clip;
    return w;
  endfunction

  // start stays high between back to back words and drops only for a gap
  task automatic send_cmd(cmd_t c);
    int gap;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 19);
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    in_op <= c.op; in_elem_index <= c.idx; in_elem_value <= c.val;
    in_px <= c.px; in_py <= c.py; in_pz <= c.pz;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_words.push_back(predict_vertex(c));
    @(negedge clk);
  endtask

  function automatic cmd_t make_cmd(logic [2:0] op, logic [3:0] idx, logic signed [31:0] val,
                                    logic signed [31:0] x, logic signed [31:0] y,
                                    logic signed [31:0] z);
    cmd_t c;
    c.op = op; c.idx = idx; c.val = val; c.px = x; c.py = y; c.pz = z;
    return c;
  endfunction

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      2: return $signed($urandom_range(0, 8 << FB)) - (4 <<< FB);
      3: return $signed($urandom_range(0, 1 << FB)) - (1 <<< (FB - 1));
      default: return $signed($urandom_range(0, 2000 << FB)) - (1000 <<< FB);
    endcase
  endfunction

  function automatic cmd_t rand_cmd();
    logic [2:0] op;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) op = OP_WR_CUR;
    else if (pick < 50) op = OP_WR_PEND;
    else if (pick < 54) op = OP_IDENT;
    else if (pick < 62) op = OP_CONCAT;
    else if (pick < 96) op = OP_XFORM;
    else op = 3'($urandom_range(OP_NOP, 7));
    return make_cmd(op, 4'($urandom), $urandom ^ rand_value(), rand_value(), rand_value(),
                    rand_value());
  endfunction

  task automatic wait_drained();
    start <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic test_extremes();
    for (int i = 0; i < 16; i++)
      send_cmd(make_cmd(OP_WR_CUR, 4'(i), (i % 2) ? 32'sh7fffffff : 32'sh80000000, 0, 0, 0));
    send_cmd(make_cmd(OP_XFORM, 4'd0, 0, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff));
    send_cmd(make_cmd(OP_XFORM, 4'd0, 0, 32'sh80000000, 32'sh80000000, -1));
    send_cmd(make_cmd(OP_WR_PEND, 4'd15, 32'sh80000000, 0, 0, 0));
    send_cmd(make_cmd(OP_WR_PEND, 4'd0, 32'sh7fffffff, 0, 0, 0));
    send_cmd(make_cmd(OP_CONCAT, 4'd0, 0, 0, 0, 0));
    send_cmd(make_cmd(OP_IDENT, 4'd0, 0, 0, 0, 0));
    send_cmd(make_cmd(OP_XFORM, 4'd0, 0, -1, 32'sh00018000, -3));
    send_cmd(make_cmd(3'd5, 4'd7, 32'sh12345678, 1, 2, 3));
    send_cmd(make_cmd(3'd7, 4'd3, -1, -1, -1, -1));
  endtask

  task automatic test_random(int n);
    cmd_t c;
    for (int i = 0; i < n; i++) begin
      c = rand_cmd();
      send_cmd(c);
    end
  endtask

  // response side: one word per strobe, cannot be held off
  always @(posedge clk) begin
    vertex_word_t w;
    if (rst_n && (start && !busy || out_valid)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (rst_n && out_valid) begin
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word qx=%h", out_qx);
      end else begin
        w = expected_words.pop_front();
        if (out_qx !== w.qx || out_qy !== w.qy || out_qz !== w.qz || out_saturated !== w.sat)
        begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp %h %h %h %b got %h %h %h %b", w.qx, w.qy, w.qz, w.sat,
                     out_qx, out_qy, out_qz, out_saturated);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!done && idle_cycles >= IDLE_LIMIT) begin
      $display("** affine_vertex_transform_engine: FAILED **");
      $finish;
    end
  end

  initial begin
    done = 0; mismatches = 0; idle_cycles = 0; gaps_on = 1;
    rst_n = 0; start = 0; in_op = OP_NOP; in_elem_index = 4'd0; in_elem_value = 0;
    in_px = 0; in_py = 0; in_pz = 0;
    for (int i = 0; i < 16; i++) pend_mtx[i] = (i % 5 == 0) ? (32'sd1 <<< FB) : 32'sd0;
    load_identity();
    repeat (8) @(negedge clk);
    rst_n = 1;
    test_extremes();
    wait_drained();
    test_random(400);
    wait_drained();
    test_random(300);
    gaps_on = 0;
    test_random(200);
    wait_drained();
    repeat (200) @(posedge clk);
    done = 1;
    if (mismatches == 0 && expected_words.size() == 0)
      $display("** affine_vertex_transform_engine: PASSED **");
    else
      $display("** affine_vertex_transform_engine: FAILED **");
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/core/avte_pkg.sv
rtl/core/avte_front.sv
rtl/core/avte_back.sv
rtl/core/affine_vertex_transform_engine.sv
tb/sv/affine_vertex_transform_engine_test.sv
